// File: hdl/huffman_code_builder_decoder_assert.svh
// Assertion macros for the Huffman code builder and decoder.
// Included by the top level; no other dependencies.
`ifndef HUFFMAN_CODE_BUILDER_DECODER_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define HCB_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("hcb assertion failed");
`define HCB_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("hcb assertion failed");
`else
`define HCB_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define HCB_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// File: hdl/hcb_pkg.sv
// Shared types, codes and the node ordering function for the Huffman block.
// No dependencies.
package hcb_pkg;

  localparam int WEIGHT_W = 32;
  localparam int SYM_W    = 8;
  localparam int NODE_W   = 9;
  localparam int CODE_W   = 64;
  localparam int LEN_W    = 7;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BUILD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DECODE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_TREE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd3;

  typedef struct packed {
    logic              leaf;
    logic [SYM_W-1:0]  sym;
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
  } link_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] w;
    logic                leaf;
    logic [SYM_W-1:0]    sym;
    logic [NODE_W-1:0]   idx;
  } okey_t;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } path_t;

  typedef struct packed {
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   root;
  } build_stat_t;

  // a sorts ahead of b in the list (heaviest first)
  function automatic logic heavier(okey_t a, okey_t b);
    logic r;
    if (a.w != b.w) r = (a.w > b.w);
    else if (!a.leaf) r = 1'b0;
    else if (!b.leaf) r = 1'b1;
    else r = (a.sym > b.sym);
    return r;
  endfunction

endpackage

// File: hdl/hcb_freq_store.sv
// Frequency table with present marks and a running count of present symbols.
// Depends on hcb_pkg.
module hcb_freq_store #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   clear,
  input  logic                                   load,
  input  logic [$clog2(SYMBOL_COUNT)-1:0]        wr_sym,
  input  logic [hcb_pkg::WEIGHT_W-1:0]           wr_freq,
  input  logic                                   rd_en,
  input  logic [$clog2(SYMBOL_COUNT)-1:0]        rd_sym,
  output logic                                   rd_present,
  output logic [hcb_pkg::WEIGHT_W-1:0]           rd_freq,
  output logic [$clog2(SYMBOL_COUNT+1)-1:0]      present_count
);

  localparam int CNT_W = $clog2(SYMBOL_COUNT+1);

  logic [SYMBOL_COUNT-1:0]        present;
  logic [hcb_pkg::WEIGHT_W-1:0]   freq_mem [SYMBOL_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      present       <= '0;
      present_count <= '0;
    end else if (clear) begin
      present       <= '0;
      present_count <= '0;
    end else if (load) begin
      present[wr_sym] <= 1'b1;
      if (!present[wr_sym]) present_count <= present_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) freq_mem[wr_sym] <= wr_freq;
    if (rd_en) begin
      rd_freq    <= freq_mem[rd_sym];
      rd_present <= present[rd_sym];
    end
  end

endmodule

// File: hdl/hcb_builder.sv
// Tree builder: sorted node list, node links and code paths, run by one
// sequencer around a shared compare/add unit. Depends on hcb_pkg.
module hcb_builder #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [$clog2(SYMBOL_COUNT+1)-1:0]     present_count,
  output logic                                  st_re,
  output logic [$clog2(SYMBOL_COUNT)-1:0]       st_sym,
  input  logic                                  st_present,
  input  logic [hcb_pkg::WEIGHT_W-1:0]          st_freq,
  output logic                                  cw_en,
  output logic [$clog2(SYMBOL_COUNT)-1:0]       cw_sym,
  output hcb_pkg::path_t                        cw_data,
  input  logic                                  dec_re,
  input  logic [hcb_pkg::NODE_W-1:0]            dec_addr,
  output hcb_pkg::link_t                        dec_links,
  output hcb_pkg::build_stat_t                  stat
);

  localparam int NODE_COUNT = 2 * SYMBOL_COUNT - 1;
  localparam int SIDX_W     = $clog2(SYMBOL_COUNT);
  localparam int CNT_W      = $clog2(SYMBOL_COUNT + 1);
  localparam int NIDX_W     = $clog2(NODE_COUNT);
  localparam int NW         = hcb_pkg::NODE_W;
  localparam int LW         = hcb_pkg::LEN_W;
  localparam int WW         = hcb_pkg::WEIGHT_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_INS      = 4'd3;
  localparam logic [3:0] S_INS_CMP  = 4'd4;
  localparam logic [3:0] S_POP1     = 4'd5;
  localparam logic [3:0] S_POP2     = 4'd6;
  localparam logic [3:0] S_POP3     = 4'd7;
  localparam logic [3:0] S_PATH_RD  = 4'd8;
  localparam logic [3:0] S_PATH_L   = 4'd9;
  localparam logic [3:0] S_PATH_R   = 4'd10;
  localparam logic [3:0] S_LEAF_RD  = 4'd11;
  localparam logic [3:0] S_LEAF_WR  = 4'd12;

  logic [3:0]          state, state_next, ret, ret_next;
  logic [NW-1:0]       made, made_next, leaves, leaves_next, idx, idx_next;
  logic [CNT_W-1:0]    cnt, cnt_next, pos, pos_next, scan, scan_next;
  hcb_pkg::okey_t      nkey, nkey_next, lkey, lkey_next;
  hcb_pkg::build_stat_t stat_next;

  hcb_pkg::okey_t      ord_mem [SYMBOL_COUNT];
  hcb_pkg::link_t      lnk_mem [NODE_COUNT];
  hcb_pkg::path_t      pth_mem [NODE_COUNT];

  logic                ord_we, ord_re, lnk_we, lnk_re, pth_we, pth_re;
  logic [SIDX_W-1:0]   ord_wa, ord_ra;
  logic [NIDX_W-1:0]   lnk_wa, lnk_ra, pth_wa, pth_ra;
  hcb_pkg::okey_t      ord_wd, ord_rd;
  hcb_pkg::link_t      lnk_wd, lnk_rd;
  hcb_pkg::path_t      pth_wd, pth_rd;
  logic [WW:0]         sum;

  assign sum       = {1'b0, lkey.w} + {1'b0, ord_rd.w};
  assign st_sym    = scan[SIDX_W-1:0];
  assign dec_links = lnk_rd;
  assign cw_sym    = SIDX_W'(lnk_rd.sym);
  assign cw_data   = pth_rd;

  always_comb begin
    state_next  = state;
    ret_next    = ret;
    made_next   = made;
    leaves_next = leaves;
    idx_next    = idx;
    cnt_next    = cnt;
    pos_next    = pos;
    scan_next   = scan;
    nkey_next   = nkey;
    lkey_next   = lkey;
    stat_next   = stat;
    stat_next.done = 1'b0;
    ord_we = 1'b0; ord_wa = pos[SIDX_W-1:0]; ord_wd = nkey;
    ord_re = 1'b0; ord_ra = SIDX_W'(pos - CNT_W'(1));
    lnk_we = 1'b0; lnk_wa = made[NIDX_W-1:0]; lnk_wd = '0;
    lnk_re = 1'b0; lnk_ra = idx[NIDX_W-1:0];
    pth_we = 1'b0; pth_wa = lnk_rd.left[NIDX_W-1:0]; pth_wd = '0;
    pth_re = 1'b0; pth_ra = idx[NIDX_W-1:0];
    st_re  = 1'b0;
    cw_en  = 1'b0;
    case (state)
      S_IDLE: begin
        lnk_re = dec_re;
        lnk_ra = dec_addr[NIDX_W-1:0];
        if (start) begin
          made_next = '0;
          cnt_next  = '0;
          scan_next = '0;
          if (present_count == CNT_W'(0)) begin
            stat_next.done   = 1'b1;
            stat_next.status = hcb_pkg::ST_NO_TREE;
          end else if (present_count == CNT_W'(1)) begin
            // lone symbol: add a weight-0 symbol-0 leaf as node 0
            lnk_we     = 1'b1;
            lnk_wa     = '0;
            lnk_wd     = '0;
            lnk_wd.leaf = 1'b1;
            nkey_next  = '0;
            nkey_next.leaf = 1'b1;
            made_next  = NW'(1);
            pos_next   = '0;
            ret_next   = S_SCAN_RD;
            state_next = S_INS;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (scan == CNT_W'(SYMBOL_COUNT)) begin
          leaves_next = made;
          state_next  = S_POP1;
        end else begin
          st_re      = 1'b1;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        scan_next = scan + CNT_W'(1);
        if (st_present) begin
          nkey_next.w    = st_freq;
          nkey_next.leaf = 1'b1;
          nkey_next.sym  = hcb_pkg::SYM_W'(scan);
          nkey_next.idx  = made;
          lnk_we         = 1'b1;
          lnk_wd.leaf    = 1'b1;
          lnk_wd.sym     = hcb_pkg::SYM_W'(scan);
          made_next      = made + NW'(1);
          pos_next       = cnt;
          ret_next       = S_SCAN_RD;
          state_next     = S_INS;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_INS: begin
        if (pos == CNT_W'(0)) begin
          ord_we     = 1'b1;
          cnt_next   = cnt + CNT_W'(1);
          state_next = ret;
        end else begin
          ord_re     = 1'b1;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ord_we = 1'b1;
        if (hcb_pkg::heavier(ord_rd, nkey)) begin
          cnt_next   = cnt + CNT_W'(1);
          state_next = ret;
        end else begin
          ord_wd     = ord_rd;
          pos_next   = pos - CNT_W'(1);
          state_next = S_INS;
        end
      end
      S_POP1: begin
        if (cnt == CNT_W'(1)) begin
          stat_next.root = made - NW'(1);
          pth_we     = 1'b1;
          pth_wa     = NIDX_W'(made - NW'(1));
          idx_next   = made - NW'(1);
          state_next = S_PATH_RD;
        end else begin
          ord_re     = 1'b1;
          ord_ra     = SIDX_W'(cnt - CNT_W'(1));
          state_next = S_POP2;
        end
      end
      S_POP2: begin
        lkey_next  = ord_rd;
        ord_re     = 1'b1;
        ord_ra     = SIDX_W'(cnt - CNT_W'(2));
        state_next = S_POP3;
      end
      S_POP3: begin
        if (sum[WW]) begin
          stat_next.done   = 1'b1;
          stat_next.status = hcb_pkg::ST_OVERFLOW;
          state_next       = S_IDLE;
        end else begin
          nkey_next      = '0;
          nkey_next.w    = sum[WW-1:0];
          nkey_next.idx  = made;
          lnk_we         = 1'b1;
          lnk_wd.left    = lkey.idx;
          lnk_wd.right   = ord_rd.idx;
          made_next      = made + NW'(1);
          cnt_next       = cnt - CNT_W'(2);
          pos_next       = cnt - CNT_W'(2);
          ret_next       = S_POP1;
          state_next     = S_INS;
        end
      end
      S_PATH_RD: begin
        if (idx < leaves) begin
          idx_next   = '0;
          state_next = S_LEAF_RD;
        end else begin
          lnk_re     = 1'b1;
          pth_re     = 1'b1;
          state_next = S_PATH_L;
        end
      end
      S_PATH_L: begin
        if (pth_rd.len >= LW'(MAX_CODE_BITS)) begin
          stat_next.done   = 1'b1;
          stat_next.status = hcb_pkg::ST_OVERFLOW;
          state_next       = S_IDLE;
        end else begin
          pth_we      = 1'b1;
          pth_wd.bits = pth_rd.bits;
          pth_wd.len  = pth_rd.len + LW'(1);
          state_next  = S_PATH_R;
        end
      end
      S_PATH_R: begin
        pth_we      = 1'b1;
        pth_wa      = lnk_rd.right[NIDX_W-1:0];
        pth_wd.bits = pth_rd.bits | (hcb_pkg::CODE_W'(1) << pth_rd.len);
        pth_wd.len  = pth_rd.len + LW'(1);
        idx_next    = idx - NW'(1);
        state_next  = S_PATH_RD;
      end
      S_LEAF_RD: begin
        if (idx == leaves) begin
          stat_next.done   = 1'b1;
          stat_next.status = hcb_pkg::ST_OK;
          state_next       = S_IDLE;
        end else begin
          lnk_re     = 1'b1;
          pth_re     = 1'b1;
          state_next = S_LEAF_WR;
        end
      end
      S_LEAF_WR: begin
        cw_en      = 1'b1;
        idx_next   = idx + NW'(1);
        state_next = S_LEAF_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stat  <= '0;
    end else begin
      state <= state_next;
      stat  <= stat_next;
    end
    ret    <= ret_next;
    made   <= made_next;
    leaves <= leaves_next;
    idx    <= idx_next;
    cnt    <= cnt_next;
    pos    <= pos_next;
    scan   <= scan_next;
    nkey   <= nkey_next;
    lkey   <= lkey_next;
  end

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (ord_re) ord_rd <= ord_mem[ord_ra];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) lnk_mem[lnk_wa] <= lnk_wd;
    if (lnk_re) lnk_rd <= lnk_mem[lnk_ra];
  end

  always_ff @(posedge clk) begin
    if (pth_we) pth_mem[pth_wa] <= pth_wd;
    if (pth_re) pth_rd <= pth_mem[pth_ra];
  end

endmodule

// File: hdl/huffman_code_builder_decoder.sv
// Top level of the Huffman code builder, code table and bit-serial decoder.
// Depends on hcb_pkg, hcb_freq_store, hcb_builder and the assertion header.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall  | command, symbol, frequency, code_bit
//  out     | out_valid / out_stall| code_bits, code_length, symbol_valid,
//          |                     | decoded_symbol, status
//
// Clear, load and unknown commands are handled in the cycle of their beat,
// the result registered: one beat per cycle while out_stall does not hold
// the output. Lookup does a code table read, decode two node link reads
// (one if parked on a leaf). Build is set by the sorted-list insertion: it
// scans each symbol, steps through insert compares, merges node pairs, walks
// the code paths of the internal nodes and writes each leaf's code; the block
// stalls its input meanwhile.
// Reset is synchronous; no clearing pass is needed (present and code-valid
// marks are flops). A result held by out_stall stalls the next input beat.
`include "huffman_code_builder_decoder_assert.svh"
module huffman_code_builder_decoder #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hcb_pkg::CMD_W-1:0]       command,
  input  logic [hcb_pkg::SYM_W-1:0]       symbol,
  input  logic [hcb_pkg::WEIGHT_W-1:0]    frequency,
  input  logic                            code_bit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hcb_pkg::CODE_W-1:0]      code_bits,
  output logic [hcb_pkg::LEN_W-1:0]       code_length,
  output logic                            symbol_valid,
  output logic [hcb_pkg::SYM_W-1:0]       decoded_symbol,
  output logic [hcb_pkg::STATUS_W-1:0]    status
);

  localparam int SIDX_W = $clog2(SYMBOL_COUNT);
  localparam int CNT_W  = $clog2(SYMBOL_COUNT + 1);
  localparam int NW     = hcb_pkg::NODE_W;

  localparam logic [2:0] T_IDLE   = 3'd0;
  localparam logic [2:0] T_BUILD  = 3'd1;
  localparam logic [2:0] T_LOOKUP = 3'd2;
  localparam logic [2:0] T_DEC1   = 3'd3;
  localparam logic [2:0] T_DEC2   = 3'd4;

  logic [2:0]              tstate, tstate_next;
  logic                    accept, sym_ok;
  logic                    tree_valid, tree_valid_next;
  logic [NW-1:0]           root, root_next, walk, walk_next, child, child_next;
  logic [SIDX_W-1:0]       lk_sym, lk_sym_next;
  logic                    dbit, dbit_next;
  logic [SYMBOL_COUNT-1:0] code_valid;
  hcb_pkg::path_t          code_mem [SYMBOL_COUNT];
  hcb_pkg::path_t          code_rd;
  logic                    code_re;

  // result staging
  logic                           emit;
  logic [hcb_pkg::CODE_W-1:0]     e_bits;
  logic [hcb_pkg::LEN_W-1:0]      e_len;
  logic                           e_sv;
  logic [hcb_pkg::SYM_W-1:0]      e_sym;
  logic [hcb_pkg::STATUS_W-1:0]   e_st;

  // store and builder hookup
  logic                           st_clear, st_load, st_re, st_present;
  logic [SIDX_W-1:0]              st_sym;
  logic [hcb_pkg::WEIGHT_W-1:0]   st_freq;
  logic [CNT_W-1:0]               present_count;
  logic                           bstart, cw_en, dec_re;
  logic [SIDX_W-1:0]              cw_sym;
  hcb_pkg::path_t                 cw_data;
  logic [NW-1:0]                  dec_addr;
  hcb_pkg::link_t                 dec_links;
  hcb_pkg::build_stat_t           bstat;

  assign in_stall = (tstate != T_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign sym_ok   = ({1'b0, symbol} < 9'(SYMBOL_COUNT));

  hcb_freq_store #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_store (
    .clk           (clk),
    .rst           (rst),
    .clear         (st_clear),
    .load          (st_load),
    .wr_sym        (symbol[SIDX_W-1:0]),
    .wr_freq       (frequency),
    .rd_en         (st_re),
    .rd_sym        (st_sym),
    .rd_present    (st_present),
    .rd_freq       (st_freq),
    .present_count (present_count)
  );

  hcb_builder #(
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_builder (
    .clk           (clk),
    .rst           (rst),
    .start         (bstart),
    .present_count (present_count),
    .st_re         (st_re),
    .st_sym        (st_sym),
    .st_present    (st_present),
    .st_freq       (st_freq),
    .cw_en         (cw_en),
    .cw_sym        (cw_sym),
    .cw_data       (cw_data),
    .dec_re        (dec_re),
    .dec_addr      (dec_addr),
    .dec_links     (dec_links),
    .stat          (bstat)
  );

  always_comb begin
    tstate_next     = tstate;
    tree_valid_next = tree_valid;
    root_next       = root;
    walk_next       = walk;
    child_next      = child;
    lk_sym_next     = lk_sym;
    dbit_next       = dbit;
    st_clear = 1'b0;
    st_load  = 1'b0;
    bstart   = 1'b0;
    code_re  = 1'b0;
    dec_re   = 1'b0;
    dec_addr = walk;
    emit   = 1'b0;
    e_bits = '0;
    e_len  = '0;
    e_sv   = 1'b0;
    e_sym  = '0;
    e_st   = hcb_pkg::ST_OK;
    case (tstate)
      T_IDLE: begin
        if (accept) begin
          case (command)
            hcb_pkg::CMD_CLEAR: begin
              st_clear = 1'b1;
              emit     = 1'b1;
            end
            hcb_pkg::CMD_LOAD: begin
              // out-of-range symbols are dropped silently
              st_load = sym_ok;
              emit    = 1'b1;
            end
            hcb_pkg::CMD_BUILD: begin
              tree_valid_next = 1'b0;
              bstart          = 1'b1;
              tstate_next     = T_BUILD;
            end
            hcb_pkg::CMD_LOOKUP: begin
              if (!tree_valid) begin
                emit = 1'b1;
                e_st = hcb_pkg::ST_NO_TREE;
              end else if (!sym_ok) begin
                emit = 1'b1;
                e_st = hcb_pkg::ST_ABSENT;
              end else begin
                code_re     = 1'b1;
                lk_sym_next = symbol[SIDX_W-1:0];
                tstate_next = T_LOOKUP;
              end
            end
            hcb_pkg::CMD_DECODE: begin
              if (!tree_valid) begin
                emit = 1'b1;
                e_st = hcb_pkg::ST_NO_TREE;
              end else begin
                dec_re      = 1'b1;
                dbit_next   = code_bit;
                tstate_next = T_DEC1;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      T_BUILD: begin
        if (bstat.done) begin
          emit        = 1'b1;
          e_st        = bstat.status;
          tstate_next = T_IDLE;
          if (bstat.status == hcb_pkg::ST_OK) begin
            tree_valid_next = 1'b1;
            root_next       = bstat.root;
            walk_next       = bstat.root;
          end
        end
      end
      T_LOOKUP: begin
        emit        = 1'b1;
        tstate_next = T_IDLE;
        if (code_valid[lk_sym]) begin
          e_bits = code_rd.bits;
          e_len  = code_rd.len;
        end else begin
          e_st = hcb_pkg::ST_ABSENT;
        end
      end
      T_DEC1: begin
        if (dec_links.leaf) begin
          // parked on a leaf: restart at the root, no symbol
          walk_next   = root;
          emit        = 1'b1;
          tstate_next = T_IDLE;
        end else begin
          child_next  = dbit ? dec_links.right : dec_links.left;
          dec_re      = 1'b1;
          dec_addr    = dbit ? dec_links.right : dec_links.left;
          tstate_next = T_DEC2;
        end
      end
      T_DEC2: begin
        emit        = 1'b1;
        tstate_next = T_IDLE;
        if (dec_links.leaf) begin
          e_sv      = 1'b1;
          e_sym     = dec_links.sym;
          walk_next = root;
        end else begin
          walk_next = child;
        end
      end
      default: tstate_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate     <= T_IDLE;
      tree_valid <= 1'b0;
      out_valid  <= 1'b0;
      code_valid <= '0;
    end else begin
      tstate     <= tstate_next;
      tree_valid <= tree_valid_next;
      if (emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      // a build drops every code before refilling the table
      if (bstart) code_valid <= '0;
      else if (cw_en) code_valid[cw_sym] <= 1'b1;
    end
    root   <= root_next;
    walk   <= walk_next;
    child  <= child_next;
    lk_sym <= lk_sym_next;
    dbit   <= dbit_next;
    if (emit) begin
      code_bits      <= e_bits;
      code_length    <= e_len;
      symbol_valid   <= e_sv;
      decoded_symbol <= e_sym;
      status         <= e_st;
    end
  end

  always_ff @(posedge clk) begin
    if (cw_en) code_mem[cw_sym] <= cw_data;
    if (code_re) code_rd <= code_mem[symbol[SIDX_W-1:0]];
  end

  // a finished build must land in a free output register
  `HCB_ASSERT_IMPLY(a_build_out_free, clk, rst, tstate == T_BUILD && bstat.done, !out_valid)
  // a build beat drops the old tree at once
  `HCB_ASSERT_NEXT(a_build_drops_tree, clk, rst, accept && command == hcb_pkg::CMD_BUILD, !tree_valid)
  // a decoded symbol only ever comes with ok status
  `HCB_ASSERT_IMPLY(a_sym_status_ok, clk, rst, out_valid && symbol_valid, status == hcb_pkg::ST_OK)

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for huffman_code_builder_decoder: random command
// streams checked against an in-bench Huffman predictor. Needs hcb_pkg.
`timescale 1ns / 100ps
module tb_top;

  localparam int SYMS      = 256;
  localparam int NODES     = 2 * SYMS - 1;
  localparam int CODE_MAX  = 64;
  localparam int CYC_LIMIT = 20000000;
  localparam int HOLD_CYC  = 400;
  localparam logic [hcb_pkg::CMD_W-1:0] CMD_BAD_LO = 3'd5;
  localparam logic [hcb_pkg::CMD_W-1:0] CMD_BAD_HI = 3'd7;

  typedef struct {
    logic [hcb_pkg::CODE_W-1:0]   bits;
    logic [hcb_pkg::LEN_W-1:0]    len;
    logic                         hit;
    logic [hcb_pkg::SYM_W-1:0]    dsym;
    logic [hcb_pkg::STATUS_W-1:0] st;
  } huff_result_t;

  // Scoreboard: mirrors the frequency table, tree, code table and decode walk.
  class huff_scoreboard;
    logic [hcb_pkg::WEIGHT_W-1:0] freq[SYMS];
    bit                           pres[SYMS];
    logic [hcb_pkg::WEIGHT_W-1:0] nw[NODES];
    bit                           nleaf[NODES];
    logic [hcb_pkg::SYM_W-1:0]    nsym[NODES];
    int unsigned                  nl[NODES], nr[NODES];
    logic [hcb_pkg::CODE_W-1:0]   cbits[SYMS];
    logic [hcb_pkg::LEN_W-1:0]    clen[SYMS];
    logic [hcb_pkg::CODE_W-1:0]   pbits[NODES];
    int unsigned                  plen[NODES];
    int unsigned                  ord[SYMS];
    int unsigned                  ocnt;
    bit                           tree_ok;
    int unsigned                  root, walk;
    huff_result_t                 pending[$];
    int                           errors, checked, builds_ok, leaves_hit;

    function new();
      for (int i = 0; i < SYMS; i++) begin
        freq[i] = '0; pres[i] = 0; cbits[i] = '0; clen[i] = '0;
      end
      tree_ok = 0; root = 0; walk = 0; ocnt = 0;
      errors = 0; checked = 0; builds_ok = 0; leaves_hit = 0;
    endfunction

    function bit ahead(int unsigned a, int unsigned b);
      if (nw[a] != nw[b]) return nw[a] > nw[b];
      if (!nleaf[a]) return 0;
      if (!nleaf[b]) return 1;
      return nsym[a] > nsym[b];
    endfunction

    // sorted insert, in front of equal-weight internal nodes
    function void place_node(int unsigned n);
      int unsigned p;
      p = 0;
      if (ocnt >= SYMS) return;
      while (p < ocnt && ahead(ord[p], n)) p++;
      for (int unsigned k = ocnt; k > p; k--) ord[k] = ord[k-1];
      ord[p] = n;
      ocnt++;
    endfunction

    function logic [hcb_pkg::STATUS_W-1:0] make_tree();
      int unsigned cnt, made, leaves, l, r;
      logic [hcb_pkg::WEIGHT_W:0] sum;
      cnt = 0; made = 0;
      for (int i = 0; i < SYMS; i++) begin cbits[i] = '0; clen[i] = '0; end
      tree_ok = 0; root = 0; walk = 0; ocnt = 0;
      for (int i = 0; i < SYMS; i++) if (pres[i]) cnt++;
      if (cnt == 0) return hcb_pkg::ST_NO_TREE;
      if (cnt == 1) begin
        // lone symbol: zero-weight symbol-0 sibling
        nw[0] = '0; nleaf[0] = 1; nsym[0] = '0;
        place_node(0); made = 1;
      end
      for (int i = 0; i < SYMS; i++) if (pres[i]) begin
        nw[made] = freq[i]; nleaf[made] = 1; nsym[made] = i[7:0];
        place_node(made); made++;
      end
      leaves = made;
      while (ocnt > 1) begin
        l = ord[ocnt-1]; r = ord[ocnt-2];
        sum = {1'b0, nw[l]} + {1'b0, nw[r]};
        ocnt -= 2;
        if (sum[hcb_pkg::WEIGHT_W] || made >= NODES) return hcb_pkg::ST_OVERFLOW;
        nw[made] = sum[hcb_pkg::WEIGHT_W-1:0]; nleaf[made] = 0; nsym[made] = '0;
        nl[made] = l; nr[made] = r;
        place_node(made); made++;
      end
      pbits[made-1] = '0; plen[made-1] = 0;
      for (int i = made - 1; i >= int'(leaves); i--) begin
        if (plen[i] >= CODE_MAX) begin
          for (int k = 0; k < SYMS; k++) clen[k] = '0;
          return hcb_pkg::ST_OVERFLOW;
        end
        pbits[nl[i]] = pbits[i]; plen[nl[i]] = plen[i] + 1;
        pbits[nr[i]] = pbits[i] | (64'd1 << plen[i]); plen[nr[i]] = plen[i] + 1;
      end
      for (int i = 0; i < int'(leaves); i++) begin
        cbits[nsym[i]] = pbits[i]; clen[nsym[i]] = plen[i][hcb_pkg::LEN_W-1:0];
      end
      root = made - 1; walk = root; tree_ok = 1;
      builds_ok++;
      return hcb_pkg::ST_OK;
    endfunction

    // accepted input beat: work out the result it causes
    function void note_beat(logic [hcb_pkg::CMD_W-1:0] c, logic [hcb_pkg::SYM_W-1:0] s,
                            logic [hcb_pkg::WEIGHT_W-1:0] f, logic b);
      huff_result_t e;
      e = '{default: '0};
      case (c)
        hcb_pkg::CMD_CLEAR:
          for (int i = 0; i < SYMS; i++) begin freq[i] = '0; pres[i] = 0; end
        hcb_pkg::CMD_LOAD: begin freq[s] = f; pres[s] = 1; end
        hcb_pkg::CMD_BUILD: e.st = make_tree();
        hcb_pkg::CMD_LOOKUP: begin
          if (!tree_ok) e.st = hcb_pkg::ST_NO_TREE;
          else if (clen[s] == 0) e.st = hcb_pkg::ST_ABSENT;
          else begin e.bits = cbits[s]; e.len = clen[s]; end
        end
        hcb_pkg::CMD_DECODE: begin
          if (!tree_ok) e.st = hcb_pkg::ST_NO_TREE;
          else if (nleaf[walk]) walk = root;
          else begin
            walk = b ? nr[walk] : nl[walk];
            if (nleaf[walk]) begin
              e.hit = 1; e.dsym = nsym[walk]; walk = root; leaves_hit++;
            end
          end
        end
        default: ;
      endcase
      pending = {pending, e};
    endfunction

    function void check_beat(huff_result_t got);
      huff_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.bits !== e.bits) begin
        $error("code_bits expected %h actual %h", e.bits, got.bits); errors++;
      end
      if (got.len !== e.len) begin
        $error("code_length expected %0d actual %0d", e.len, got.len); errors++;
      end
      if (got.hit !== e.hit) begin
        $error("symbol_valid expected %0d actual %0d", e.hit, got.hit); errors++;
      end
      if (got.dsym !== e.dsym) begin
        $error("decoded_symbol expected %0d actual %0d", e.dsym, got.dsym); errors++;
      end
      if (got.st !== e.st) begin
        $error("status expected %0d actual %0d", e.st, got.st); errors++;
      end
    endfunction
  endclass

  logic                         clk = 0, rst = 1;
  logic                         in_valid = 0, out_stall = 0;
  logic [hcb_pkg::CMD_W-1:0]    command = '0;
  logic [hcb_pkg::SYM_W-1:0]    symbol = '0;
  logic [hcb_pkg::WEIGHT_W-1:0] frequency = '0;
  logic                         code_bit = 0;
  logic                         in_stall, out_valid, symbol_valid;
  logic [hcb_pkg::CODE_W-1:0]   code_bits;
  logic [hcb_pkg::LEN_W-1:0]    code_length;
  logic [hcb_pkg::SYM_W-1:0]    decoded_symbol;
  logic [hcb_pkg::STATUS_W-1:0] status;

  huff_scoreboard sb = new();
  bit  gaps_on = 1;   // random idling on both sides
  bit  hold_req = 0;  // receiver long hold-off request
  int  cycles = 0;
  int  beats_sent = 0;
  logic [hcb_pkg::SYM_W-1:0] loaded[$];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  huffman_code_builder_decoder u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .symbol(symbol), .frequency(frequency), .code_bit(code_bit),
    .out_valid(out_valid), .out_stall(out_stall),
    .code_bits(code_bits), .code_length(code_length), .symbol_valid(symbol_valid),
    .decoded_symbol(decoded_symbol), .status(status)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("huffman_code_builder_decoder test failed");
      $finish;
    end
  end

  // result side: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 0;
      end
      out_stall <= gaps_on && ($urandom_range(99) < 35);
    end
  end

  // result monitor
  always @(posedge clk) begin
    huff_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.bits = code_bits; got.len = code_length; got.hit = symbol_valid;
      got.dsym = decoded_symbol; got.st = status;
      sb.check_beat(got);
    end
  end

  // one input beat; the payload holds while stalled
  task automatic send(logic [hcb_pkg::CMD_W-1:0] c, logic [hcb_pkg::SYM_W-1:0] s,
                      logic [hcb_pkg::WEIGHT_W-1:0] f, logic b);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 35) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; command <= c; symbol <= s; frequency <= f; code_bit <= b;
    do @(posedge clk); while (in_stall);
    sb.note_beat(c, s, f, b);
    beats_sent++;
  endtask

  task automatic send_cmd(logic [hcb_pkg::CMD_W-1:0] c, logic [hcb_pkg::SYM_W-1:0] s);
    send(c, s, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [hcb_pkg::WEIGHT_W-1:0] pick_weight();
    int k;
    k = $urandom_range(9);
    if (k < 5) return $urandom_range(1, 20);
    if (k < 7) return $urandom_range(0, 1000);
    if (k < 8) return 0;
    return $urandom;  // full width, may overflow
  endfunction

  initial begin
    int nsym, nops, k;
    logic [hcb_pkg::SYM_W-1:0] s;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: no tree, empty build, unknown codes
    send_cmd(hcb_pkg::CMD_LOOKUP, 8'd3);
    send_cmd(hcb_pkg::CMD_DECODE, 8'd0);
    send_cmd(hcb_pkg::CMD_BUILD, 8'd0);
    send_cmd(CMD_BAD_LO, 8'hff);
    send_cmd(CMD_BAD_HI, 8'h00);
    // lone symbol 200: zero-weight symbol-0 sibling
    send(hcb_pkg::CMD_LOAD, 8'd200, 32'd7, 1'b0);
    send_cmd(hcb_pkg::CMD_BUILD, 8'd0);
    send_cmd(hcb_pkg::CMD_LOOKUP, 8'd200);
    send_cmd(hcb_pkg::CMD_LOOKUP, 8'd0);
    send_cmd(hcb_pkg::CMD_LOOKUP, 8'd1);
    send(hcb_pkg::CMD_DECODE, 8'd0, 32'd0, 1'b1);
    send(hcb_pkg::CMD_DECODE, 8'd0, 32'd0, 1'b0);
    // lone symbol 0 gets code "1"; clear keeps the old tree
    send_cmd(hcb_pkg::CMD_CLEAR, 8'd0);
    send_cmd(hcb_pkg::CMD_LOOKUP, 8'd200);
    send(hcb_pkg::CMD_LOAD, 8'd0, 32'hffffffff, 1'b0);
    send_cmd(hcb_pkg::CMD_BUILD, 8'd0);
    send_cmd(hcb_pkg::CMD_LOOKUP, 8'd0);
    // weight overflow, then repeat load overwrites
    send(hcb_pkg::CMD_LOAD, 8'd255, 32'hffffffff, 1'b1);
    send_cmd(hcb_pkg::CMD_BUILD, 8'd0);
    send_cmd(hcb_pkg::CMD_LOOKUP, 8'd255);
    send(hcb_pkg::CMD_LOAD, 8'd255, 32'd1, 1'b1);
    send_cmd(hcb_pkg::CMD_BUILD, 8'd0);
    send_cmd(hcb_pkg::CMD_LOOKUP, 8'd255);
    drain();

    // all 256 symbols once: the largest build
    gaps_on = 0;
    send_cmd(hcb_pkg::CMD_CLEAR, 8'd0);
    for (int i = 0; i < SYMS; i++)
      send(hcb_pkg::CMD_LOAD, i[7:0], $urandom_range(0, 50000), 1'b0);
    send_cmd(hcb_pkg::CMD_BUILD, 8'd0);
    for (int i = 0; i < 16; i++) send_cmd(hcb_pkg::CMD_LOOKUP, 8'($urandom));
    for (int i = 0; i < 40; i++) send_cmd(hcb_pkg::CMD_DECODE, 8'd0);
    gaps_on = 1;
    drain();

    // random phases: clear, load, build, then lookups and decodes
    for (int ph = 0; beats_sent < 2000; ph++) begin
      gaps_on = (ph % 12) != 5;  // one stretch in twelve runs gap-free
      if ($urandom_range(9) != 0) begin
        send_cmd(hcb_pkg::CMD_CLEAR, 8'($urandom));
        loaded.delete();
      end
      k = $urandom_range(19);
      nsym = (k < 15) ? $urandom_range(2, 10) : (k < 19) ? $urandom_range(1, 40) : 0;
      for (int i = 0; i < nsym; i++) begin
        s = 8'($urandom);
        loaded = {loaded, s};
        send(hcb_pkg::CMD_LOAD, s, pick_weight(), 1'($urandom_range(1)));
      end
      send_cmd(hcb_pkg::CMD_BUILD, 8'($urandom));
      if (ph == 7) hold_req = 1;  // long receiver hold-off; input backs up
      nops = $urandom_range(10, 40);
      for (int i = 0; i < nops; i++) begin
        k = $urandom_range(99);
        if (k < 30 && loaded.size() > 0)
          send_cmd(hcb_pkg::CMD_LOOKUP, loaded[$urandom_range(loaded.size() - 1)]);
        else if (k < 38) send_cmd(hcb_pkg::CMD_LOOKUP, 8'($urandom));
        else if (k < 90) send_cmd(hcb_pkg::CMD_DECODE, 8'($urandom));
        else if (k < 94)
          send_cmd(hcb_pkg::CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)), 8'($urandom));
        else begin
          s = 8'($urandom);
          loaded = {loaded, s};
          send(hcb_pkg::CMD_LOAD, s, pick_weight(), 1'($urandom_range(1)));
        end
      end
      if (ph % 15 == 3) drain();  // sender pauses until all results are in
    end
    gaps_on = 1;
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d beats, %0d results checked, %0d good builds, %0d symbols decoded",
             beats_sent, sb.checked, sb.builds_ok, sb.leaves_hit);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("huffman_code_builder_decoder test passed");
    else
      $display("huffman_code_builder_decoder test failed");
    $finish;
  end
endmodule
